// ===== rtl/core/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg: shared definitions for the polynomial drift subtractor
// Register map, fixed field widths and accumulator limits used by the core
// and its channel interfaces.
// ----------------------------------------------------------------------------
package pds_pkg;

	// Fixed field widths.
	localparam int COORD_W    = 32;
	localparam int COEFF_W    = 32;
	localparam int DEGREE_W   = 3;
	localparam int NUM_COEFFS = 7;

	// Drift accumulator is signed 40 bits, Q24.16 scale.
	localparam int ACC_W = 40;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes; coefficient i sits at REG_COEFF_0 + i.
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = 3'd1;

	// Reset values.
	localparam logic [DEGREE_W-1:0] DEGREE_RESET = 3'd1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

endpackage

// ===== rtl/core/pds_if.sv =====
// ----------------------------------------------------------------------------
// pds channel interfaces
// Valid/ready channels for incoming points and corrected points. A request
// moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface pds_in_if #(
	parameter int INDEX_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic [INDEX_BITS-1:0]         point_index;
	logic signed [pds_pkg::COORD_W-1:0] x_coord;
	logic signed [pds_pkg::COORD_W-1:0] y_coord;
	logic signed [pds_pkg::COORD_W-1:0] z_value;

	modport source (output valid, point_index, x_coord, y_coord, z_value, input ready);
	modport sink (input valid, point_index, x_coord, y_coord, z_value, output ready);
endinterface

interface pds_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pds_pkg::COORD_W-1:0] x_out;
	logic signed [pds_pkg::COORD_W-1:0] y_out;
	logic signed [pds_pkg::COORD_W-1:0] z_corrected;
	logic                               saturated;

	modport source (output valid, x_out, y_out, z_corrected, saturated, input ready);
	modport sink (input valid, x_out, y_out, z_corrected, saturated, output ready);
endinterface

// ===== rtl/core/polynomial_drift_subtractor_unit.sv =====
// ----------------------------------------------------------------------------
// polynomial_drift_subtractor_unit
// Subtracts a configurable drift polynomial of the point index from z.
// ----------------------------------------------------------------------------
// The unit takes one request per clock and returns one corrected point per
// request, in order, with x and y passed through. The pipeline has one
// entry stage, a multiply stage and an accumulate stage for each Horner
// step, and the output register. The sustained rate of one point per cycle
// is set by the pipelined Horner chain, where each Horner step has its own
// 40 x (INDEX_BITS+1) multiplier. When the output is stalled the whole
// pipeline holds. The drift is p(u) = sum coeff_i * u^i with
// u = point_index / 2^INDEX_BITS, evaluated with floor rounding and
// clipped to 40 bits after every step; the result is clipped to 32 bits
// and any clip raises saturated. Write degree and coefficients only while
// no request is in flight.
module polynomial_drift_subtractor_unit #(
	parameter int MAX_DEGREE = 6,
	parameter int INDEX_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pds_pkg::CFG_DATA_W-1:0]    cfg_data,
	pds_in_if.sink                            point_in,
	pds_out_if.source                         point_out
);
	import pds_pkg::*;

	localparam int NSTG   = MAX_DEGREE + 1;
	localparam int PROD_W = ACC_W + INDEX_BITS + 1;
	localparam int SUM_W  = ACC_W + 2;
	localparam int DIFF_W = ACC_W + 1;

	// Configuration registers.
	logic [DEGREE_W-1:0] degree_q;
	coeff_t              coeff_q [NUM_COEFFS];

	// Accumulate stages; index 0 is the entry stage.
	logic                  acc_vld_s [NSTG];
	logic [INDEX_BITS-1:0] acc_idx_s [NSTG];
	coord_t                acc_x_s   [NSTG];
	coord_t                acc_y_s   [NSTG];
	coord_t                acc_z_s   [NSTG];
	acc_t                  acc_val_s [NSTG];
	logic                  acc_sat_s [NSTG];

	// Multiply stages; index k feeds accumulate stage k.
	logic                     mul_vld_s  [NSTG];
	logic [INDEX_BITS-1:0]    mul_idx_s  [NSTG];
	coord_t                   mul_x_s    [NSTG];
	coord_t                   mul_y_s    [NSTG];
	coord_t                   mul_z_s    [NSTG];
	logic signed [PROD_W-1:0] mul_prod_s [NSTG];
	logic                     mul_sat_s  [NSTG];

	// Output register.
	logic   out_vld_q;
	coord_t out_x_q;
	coord_t out_y_q;
	coord_t out_z_q;
	logic   out_sat_q;

	logic adv;
	logic signed [DIFF_W-1:0] diff;
	coord_t                   z_clip;
	logic                     z_ovf;

	// The pipeline moves as one whenever the output register can take data.
	assign adv            = !out_vld_q || point_out.ready;
	assign point_in.ready = adv;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RESET;
			for (int i = 0; i < NUM_COEFFS; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEGREE: begin
					degree_q <= cfg_data[DEGREE_W-1:0];
				end
				default: begin
					coeff_q[CFG_IDX_W'(cfg_index - REG_COEFF_0)] <= coeff_t'(cfg_data);
				end
			endcase
		end
	end

	// Entry stage: the accumulator starts with the top coefficient if used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_s[0] <= 1'b0;
		end else if (adv) begin
			acc_vld_s[0] <= point_in.valid;
		end
	end

	generate
		if (MAX_DEGREE < NUM_COEFFS) begin : g_top_coeff
			always_ff @(posedge clk) begin
				if (adv) begin
					acc_val_s[0] <= (degree_q >= DEGREE_W'(MAX_DEGREE))
						? ACC_W'(coeff_q[MAX_DEGREE]) : '0;
				end
			end
		end else begin : g_top_zero
			always_ff @(posedge clk) begin
				if (adv) begin
					acc_val_s[0] <= '0;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_idx_s[0] <= point_in.point_index;
			acc_x_s[0]   <= point_in.x_coord;
			acc_y_s[0]   <= point_in.y_coord;
			acc_z_s[0]   <= point_in.z_value;
			acc_sat_s[0] <= 1'b0;
		end
	end

	// Slot zero of the multiply arrays carries no stage.
	assign mul_vld_s[0]  = 1'b0;
	assign mul_idx_s[0]  = '0;
	assign mul_x_s[0]    = '0;
	assign mul_y_s[0]    = '0;
	assign mul_z_s[0]    = '0;
	assign mul_prod_s[0] = '0;
	assign mul_sat_s[0]  = 1'b0;

	// One multiply stage and one accumulate stage per Horner step.
	generate
		for (genvar k = 1; k < NSTG; k++) begin : g_step
			localparam int J = MAX_DEGREE - k;

			coeff_t                   addend;
			logic signed [PROD_W-1:0] prod_sh;
			logic signed [SUM_W-1:0]  sum;
			logic                     ovf;
			acc_t                     acc_next;

			// Coefficient J counts only when it is at or below the degree.
			if (J < NUM_COEFFS) begin : g_coeff
				assign addend = (degree_q >= DEGREE_W'(J)) ? coeff_q[J] : '0;
			end else begin : g_zero
				assign addend = '0;
			end

			// Multiply stage.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mul_vld_s[k] <= 1'b0;
				end else if (adv) begin
					mul_vld_s[k] <= acc_vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					mul_prod_s[k] <= acc_val_s[k-1] * $signed({1'b0, acc_idx_s[k-1]});
					mul_idx_s[k]  <= acc_idx_s[k-1];
					mul_x_s[k]    <= acc_x_s[k-1];
					mul_y_s[k]    <= acc_y_s[k-1];
					mul_z_s[k]    <= acc_z_s[k-1];
					mul_sat_s[k]  <= acc_sat_s[k-1];
				end
			end

			// Floor scaling, coefficient add and 40-bit clip.
			always_comb begin
				prod_sh = mul_prod_s[k] >>> INDEX_BITS;
				sum     = SUM_W'($signed(prod_sh[ACC_W:0])) + SUM_W'(addend);
				ovf     = (sum[SUM_W-1:ACC_W-1] != '0) && (sum[SUM_W-1:ACC_W-1] != '1);
				if (!ovf) begin
					acc_next = sum[ACC_W-1:0];
				end else if (sum[SUM_W-1]) begin
					acc_next = {1'b1, {(ACC_W-1){1'b0}}};
				end else begin
					acc_next = {1'b0, {(ACC_W-1){1'b1}}};
				end
			end

			// Accumulate stage.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					acc_vld_s[k] <= 1'b0;
				end else if (adv) begin
					acc_vld_s[k] <= mul_vld_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					acc_val_s[k] <= acc_next;
					acc_idx_s[k] <= mul_idx_s[k];
					acc_x_s[k]   <= mul_x_s[k];
					acc_y_s[k]   <= mul_y_s[k];
					acc_z_s[k]   <= mul_z_s[k];
					acc_sat_s[k] <= mul_sat_s[k] || ovf;
				end
			end
		end
	endgenerate

	// Height minus drift, clipped to 32 bits.
	always_comb begin
		diff  = DIFF_W'(acc_z_s[MAX_DEGREE]) - DIFF_W'(acc_val_s[MAX_DEGREE]);
		z_ovf = (diff[DIFF_W-1:COORD_W-1] != '0) && (diff[DIFF_W-1:COORD_W-1] != '1);
		if (!z_ovf) begin
			z_clip = diff[COORD_W-1:0];
		end else if (diff[DIFF_W-1]) begin
			z_clip = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			z_clip = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= acc_vld_s[MAX_DEGREE];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q   <= acc_x_s[MAX_DEGREE];
			out_y_q   <= acc_y_s[MAX_DEGREE];
			out_z_q   <= z_clip;
			out_sat_q <= acc_sat_s[MAX_DEGREE] || z_ovf;
		end
	end

	assign point_out.valid       = out_vld_q;
	assign point_out.x_out       = out_x_q;
	assign point_out.y_out       = out_y_q;
	assign point_out.z_corrected = out_z_q;
	assign point_out.saturated   = out_sat_q;

endmodule

// ===== rtl/core/pds_checker.sv =====
// ----------------------------------------------------------------------------
// pds_checker: port-level checks for the drift subtractor
// Watches both channels and the flow control between them.
// ----------------------------------------------------------------------------
module pds_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [pds_pkg::COORD_W-1:0] out_z,
	input logic                              out_sat
);
	import pds_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_z) && $stable(out_sat))
		else $error("result changed while stalled");

	// With the output register free the unit takes a new request.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// A stalled output holds the whole pipeline, so no request may enter.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during output stall");

endmodule

bind polynomial_drift_subtractor_unit pds_checker u_pds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (point_in.ready),
	.out_valid (point_out.valid),
	.out_ready (point_out.ready),
	.out_z     (point_out.z_corrected),
	.out_sat   (point_out.saturated)
);

// ===== dv/polynomial_drift_subtractor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_drift_subtractor_unit_tb: self-checking bench for the drift unit
// A short directed list of register writes and points comes first. It covers
// the field extremes, clipping in both directions, degree masking and
// clamping, and floor rounding of negative products. Random register
// settings and random points follow. Both channels idle at random. Every
// corrected point is compared field by field with a local fixed-point Horner
// evaluation of the drift polynomial; typed rows set their own z and flag.
// ----------------------------------------------------------------------------
module polynomial_drift_subtractor_unit_tb;
	import pds_pkg::*;

	localparam int MAX_DEGREE       = 6;
	localparam int INDEX_BITS       = 24;
	localparam int LATENCY          = 2 * MAX_DEGREE + 2;
	localparam int QUIET_LIMIT      = 4000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int RANDOM_PHASES    = 12;
	localparam int POINTS_PER_PHASE = 150;
	localparam int STALL_PERCENT    = 12;

	localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN = -(longint'(1) <<< (ACC_W - 1));
	localparam longint Z_MAX   = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint Z_MIN   = -(longint'(1) <<< (COORD_W - 1));

	localparam logic [INDEX_BITS-1:0] INDEX_TOP = '1;
	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   sat;
	} corrected_point_t;

	typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  reg_data;
		logic [INDEX_BITS-1:0]  idx;
		coord_t                 x;
		coord_t                 y;
		coord_t                 z;
		bit                     typed;
		coord_t                 z_exp;
		logic                   sat_exp;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pds_in_if #(.INDEX_BITS(INDEX_BITS)) point_in_ch ();
	pds_out_if                           point_out_ch ();

	polynomial_drift_subtractor_unit #(
		.MAX_DEGREE(MAX_DEGREE),
		.INDEX_BITS(INDEX_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.point_in(point_in_ch),
		.point_out(point_out_ch)
	);

	// Local copy of the register file, updated as each write is issued.
	logic [DEGREE_W-1:0] drift_degree;
	coeff_t              drift_coeff [NUM_COEFFS];

	corrected_point_t expected_points [$];
	stim_row_t        directed_rows [$];

	bit steady;
	int mismatch_count;
	int results_checked;
	int clipped_seen;
	int points_sent;
	int settings_written;
	int quiet_cycles;

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [CFG_IDX_W-1:0] coeff_reg(input int power);
		return REG_COEFF_0 + CFG_IDX_W'(power);
	endfunction

	// Horner evaluation with floor division, 40-bit clipping after every step
	// and a 32-bit clip of the corrected height.
	function automatic corrected_point_t remove_drift(input logic [INDEX_BITS-1:0] idx,
			input coord_t x, input coord_t y, input coord_t z);
		corrected_point_t r;
		longint acc;
		longint diff;
		int d;
		bit clip;
		clip = 1'b0;
		d = (drift_degree > MAX_DEGREE) ? MAX_DEGREE : int'(drift_degree);
		acc = longint'(drift_coeff[d]);
		for (int i = d; i > 0; i--) begin
			acc = ((acc * longint'({40'd0, idx})) >>> INDEX_BITS) + longint'(drift_coeff[i-1]);
			if (acc > ACC_MAX) begin
				acc = ACC_MAX;
				clip = 1'b1;
			end else if (acc < ACC_MIN) begin
				acc = ACC_MIN;
				clip = 1'b1;
			end
		end
		diff = longint'(z) - acc;
		if (diff > Z_MAX) begin
			diff = Z_MAX;
			clip = 1'b1;
		end else if (diff < Z_MIN) begin
			diff = Z_MIN;
			clip = 1'b1;
		end
		r.x = x;
		r.y = y;
		r.z = coord_t'(diff);
		r.sat = clip;
		return r;
	endfunction

	// Directed list helpers.
	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{kind: ROW_WRITE, default: '0};
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_data = data;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_point(input logic [INDEX_BITS-1:0] idx, input coord_t x,
			input coord_t y, input coord_t z, input bit typed, input coord_t z_exp,
			input logic sat_exp);
		stim_row_t row;
		row = '{kind: ROW_POINT, default: '0};
		row.kind = ROW_POINT;
		row.idx = idx;
		row.x = x;
		row.y = y;
		row.z = z;
		row.typed = typed;
		row.z_exp = z_exp;
		row.sat_exp = sat_exp;
		directed_rows.push_back(row);
	endfunction

	function automatic void build_directed_rows();
		// Reset registers: degree one, all coefficients zero, so z passes through.
		add_point('0, '0, '0, '0, 1, '0, 1'b0);
		add_point(INDEX_TOP, COORD_MAX, COORD_MIN, COORD_MAX, 1, COORD_MAX, 1'b0);
		add_point('0, COORD_MIN, COORD_MAX, COORD_MIN, 1, COORD_MIN, 1'b0);
		add_point(24'hAAAAAA, -32'sd1, '0, -32'sd1, 1, -32'sd1, 1'b0);
		// Degree zero written with junk in the upper bits; drift is the most
		// negative constant, so the height clips high.
		add_write(coeff_reg(0), COORD_MIN);
		add_write(REG_DEGREE, 32'hFFFF_FFF8);
		add_point(INDEX_TOP, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, '0, 1, COORD_MAX, 1'b1);
		add_point(24'h555555, 32'sh1234_5678, 32'sh8765_4321, -32'sd1, 1, COORD_MAX, 1'b0);
		add_point('0, '0, '0, COORD_MIN, 1, '0, 1'b0);
		// Most positive constant: the height clips low.
		add_write(coeff_reg(0), COORD_MAX);
		add_point(24'h123456, 32'sh0000_0001, 32'shFFFF_FFFE, COORD_MIN, 1, COORD_MIN, 1'b1);
		add_point(INDEX_TOP, '0, '0, COORD_MAX, 1, '0, 1'b0);
		// Full degree with every coefficient at its maximum.
		for (int i = 0; i < NUM_COEFFS; i++)
			add_write(coeff_reg(i), COORD_MAX);
		add_write(REG_DEGREE, 32'd6);
		add_point(INDEX_TOP, '0, '0, '0, 0, '0, 1'b0);
		add_point('0, '0, '0, COORD_MAX, 1, '0, 1'b0);
		add_point(24'h800000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678, 0, '0, 1'b0);
		// Degree seven is clamped to the top power.
		add_write(REG_DEGREE, 32'd7);
		add_point(INDEX_TOP, '0, '0, COORD_MIN, 0, '0, 1'b0);
		// Full degree with every coefficient at its minimum.
		for (int i = 0; i < NUM_COEFFS; i++)
			add_write(coeff_reg(i), COORD_MIN);
		add_write(REG_DEGREE, 32'd6);
		add_point(INDEX_TOP, '0, '0, COORD_MAX, 0, '0, 1'b0);
		add_point('0, '0, '0, '0, 1, COORD_MAX, 1'b1);
		// Drift of u squared with a unit coefficient.
		add_write(REG_DEGREE, 32'd2);
		add_write(coeff_reg(2), 32'h0001_0000);
		add_write(coeff_reg(1), 32'h0);
		add_write(coeff_reg(0), 32'h0);
		add_point(24'h800000, '0, '0, '0, 0, '0, 1'b0);
		add_point(24'h400000, '0, '0, 32'sh0001_0000, 0, '0, 1'b0);
		// A product of minus one rounds down to minus one, never to zero.
		add_write(REG_DEGREE, 32'd1);
		add_write(coeff_reg(1), 32'hFFFF_FFFF);
		add_point(24'h000001, '0, '0, '0, 1, 32'sd1, 1'b0);
		add_point(INDEX_TOP, '0, '0, '0, 1, 32'sd1, 1'b0);
		add_point('0, '0, '0, '0, 1, '0, 1'b0);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_coeff(input int phase);
		if (phase == 2)
			return COORD_MAX;
		if (phase == 3)
			return COORD_MIN;
		case ($urandom_range(0, 5))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return CFG_DATA_W'(signed'($urandom_range(0, 1 << 21)) - (1 << 20));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [INDEX_BITS-1:0] pick_index();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return INDEX_TOP;
			default: return INDEX_BITS'($urandom);
		endcase
	endfunction

	function automatic coord_t pick_height();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Offer one point, wait for the request to be taken and queue its result.
	task automatic send_point(input logic [INDEX_BITS-1:0] idx, input coord_t x,
			input coord_t y, input coord_t z, input bit typed, input coord_t z_exp,
			input logic sat_exp);
		corrected_point_t want;
		while (!steady && $urandom_range(0, 99) < STALL_PERCENT) begin
			@(negedge clk);
			point_in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		point_in_ch.valid <= 1'b1;
		point_in_ch.point_index <= idx;
		point_in_ch.x_coord <= x;
		point_in_ch.y_coord <= y;
		point_in_ch.z_value <= z;
		@(posedge clk);
		while (!point_in_ch.ready)
			@(posedge clk);
		want = remove_drift(idx, x, y, z);
		if (typed) begin
			want.z = z_exp;
			want.sat = sat_exp;
		end
		expected_points.push_back(want);
		points_sent++;
	endtask

	// Stop offering points and let every queued result come back.
	task automatic drain_pipeline();
		@(negedge clk);
		point_in_ch.valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEGREE)
			drift_degree = data[DEGREE_W-1:0];
		else
			drift_coeff[idx - REG_COEFF_0] = coeff_t'(data);
	endtask

	task automatic flag_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MISMATCHES)
			$display("mismatch on %s at result %0d: expected %h, got %h",
				field, results_checked, want, got);
	endtask

	// Result sink: random stalls, except during the steady stretch.
	always @(negedge clk) begin
		point_out_ch.ready <= steady || ($urandom_range(0, 99) >= STALL_PERCENT);
	end

	// Compare every corrected point with the oldest queued expectation.
	always @(posedge clk) begin : check_results
		corrected_point_t want;
		if (arst_n && point_out_ch.valid && point_out_ch.ready) begin
			if (expected_points.size() == 0) begin
				flag_mismatch("unexpected result z", 'x, point_out_ch.z_corrected);
			end else begin
				want = expected_points.pop_front();
				results_checked++;
				if (point_out_ch.saturated === 1'b1)
					clipped_seen++;
				if (point_out_ch.x_out !== want.x)
					flag_mismatch("x_out", want.x, point_out_ch.x_out);
				if (point_out_ch.y_out !== want.y)
					flag_mismatch("y_out", want.y, point_out_ch.y_out);
				if (point_out_ch.z_corrected !== want.z)
					flag_mismatch("z_corrected", want.z, point_out_ch.z_corrected);
				if (point_out_ch.saturated !== want.sat)
					flag_mismatch("saturated", 32'(want.sat), 32'(point_out_ch.saturated));
			end
		end
	end

	// Watchdog: end the run when no request moves on either side for too long.
	always @(posedge clk) begin
		if ((point_in_ch.valid && point_in_ch.ready) ||
				(point_out_ch.valid && point_out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no request moved for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Main sequence: reset, directed rows, then random register settings.
	initial begin
		stim_row_t row;
		bit after_point;
		logic [CFG_DATA_W-1:0] degree_word;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		point_in_ch.valid = 1'b0;
		point_in_ch.point_index = '0;
		point_in_ch.x_coord = '0;
		point_in_ch.y_coord = '0;
		point_in_ch.z_value = '0;
		point_out_ch.ready = 1'b0;
		steady = 1'b0;
		quiet_cycles = 0;
		mismatch_count = 0;
		results_checked = 0;
		clipped_seen = 0;
		points_sent = 0;
		settings_written = 0;
		after_point = 1'b0;
		drift_degree = DEGREE_RESET;
		for (int i = 0; i < NUM_COEFFS; i++)
			drift_coeff[i] = '0;
		build_directed_rows();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows; registers change only once the pipeline is empty.
		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			if (row.kind == ROW_WRITE) begin
				if (after_point) begin
					drain_pipeline();
					settings_written++;
				end
				write_reg(row.reg_idx, row.reg_data);
				after_point = 1'b0;
			end else begin
				send_point(row.idx, row.x, row.y, row.z, row.typed, row.z_exp, row.sat_exp);
				after_point = 1'b1;
			end
		end

		// Random phases, each with a fresh value in every register.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_pipeline();
			steady = (phase == 4 || phase == 5);
			degree_word = $urandom;
			case (phase)
				0: degree_word[DEGREE_W-1:0] = '0;
				1: degree_word[DEGREE_W-1:0] = '1;
				2: degree_word[DEGREE_W-1:0] = DEGREE_W'(MAX_DEGREE);
				default: degree_word[DEGREE_W-1:0] = DEGREE_W'($urandom_range(0, 7));
			endcase
			write_reg(REG_DEGREE, degree_word);
			for (int i = 0; i < NUM_COEFFS; i++)
				write_reg(coeff_reg(i), pick_coeff(phase));
			settings_written++;
			for (int n = 0; n < POINTS_PER_PHASE; n++)
				send_point(pick_index(), coord_t'($urandom), coord_t'($urandom), pick_height(),
					0, '0, 1'b0);
		end

		drain_pipeline();
		repeat (LATENCY) @(posedge clk);

		if (expected_points.size() != 0) begin
			$display("%0d corrected points never arrived", expected_points.size());
			mismatch_count += expected_points.size();
		end
		$display("covered %0d points over %0d register settings, %0d of them clipped",
			points_sent, settings_written + 1, clipped_seen);
		$display("%0d results compared, %0d field mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== polynomial_drift_subtractor_unit.f =====
rtl/core/pds_pkg.sv
rtl/core/pds_if.sv
rtl/core/polynomial_drift_subtractor_unit.sv
rtl/core/pds_checker.sv
dv/polynomial_drift_subtractor_unit_tb.sv
